[hw/rtl/fbfla_pkg.sv]
`default_nettype none

package fbfla_pkg;

  localparam int unsigned CNT_W    = 9;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned APB_AW   = 2;
  localparam int unsigned APB_DW   = 32;

  localparam logic [OP_W-1:0] OP_ALLOC     = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE      = 2'd1;
  localparam logic [OP_W-1:0] OP_RESET_ALL = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY     = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  localparam logic [APB_AW-1:0] REG_BLOCK_COUNT = 2'd0;
  localparam logic [CNT_W-1:0]  BLOCK_COUNT_RST = 9'd256;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] block_index;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    granted_index;
    logic                is_free;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_WAIT,
    S_RESET_LOOP,
    S_QUERY_CHECK,
    S_QUERY_WAIT,
    S_DONE
  } seq_state_e;

endpackage

`default_nettype wire

[hw/rtl/fixed_block_free_list_allocator.sv]
// Fixed-size block pool allocator, kept as a LIFO free list of block indices.
// Requests arrive on the in channel (valid/ready) as an op and a block index;
// each request produces exactly one result transaction on the out channel.
// Ops: allocate pops the head, free pushes an index, reset-all links blocks
// 0 to count-1 in ascending order, and query walks the list for a block.
// block_count is written through the APB port at address 0; the user must do so
// only while idle, as the block itself does not enforce it. Free goes straight
// to the result, allocate waits on one link memory read, reset-all writes one
// link per step, and query reads one link per step up to the count. The next
// request is taken as the sequencer hands its result on.
// The result lands in an output register, so the next request is taken while
// a result waits; a stalled receiver only holds the block once the sequencer
// finishes another request behind it.
// After reset the pool is empty, block_count is 256, and the link memory is
// uninitialized; issue reset-all to fill the pool. No clearing pass is run.
`default_nettype none

module fixed_block_free_list_allocator
  import fbfla_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire in_item_t          in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output out_item_t              out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  localparam int unsigned AW  = $clog2(MAX_BLOCKS);
  localparam int unsigned LW  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CAP = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;
  localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(CAP);

  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_eff;
  logic             cfg_we;

  logic      res_valid;
  logic      res_ready;
  out_item_t res;
  logic      out_valid_q;
  out_item_t out_q;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [LW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [LW-1:0] mem_rdata;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == REG_BLOCK_COUNT);
  assign prdata = (paddr == REG_BLOCK_COUNT) ? APB_DW'(count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= BLOCK_COUNT_RST;
    end else if (cfg_we) begin
      count_q <= pwdata[CNT_W-1:0];
    end
  end

  // Block indices are 8 bits wide, so the count never reaches past 256.
  assign count_eff = (count_q > COUNT_CAP) ? COUNT_CAP : count_q;

  fbfla_seq #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .AW        (AW),
    .LW        (LW)
  ) u_seq (
    .clk_i,
    .rst_ni,
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_i       (in_data_i),
    .count_i     (count_eff),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  fbfla_link_mem #(
    .DEPTH(MAX_BLOCKS),
    .AW   (AW),
    .DW   (LW)
  ) u_link_mem (
    .clk_i,
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(res_valid))
    else $error("output register loaded without a finished result");

  a_empty_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == ST_EMPTY))
      |-> ((out_data_o.granted_index == '0) && !out_data_o.is_free))
    else $error("empty pool result carries a grant or a query hit");

  a_free_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.is_free)
      |-> ((out_data_o.status == ST_OK) && (out_data_o.granted_index == '0)))
    else $error("query hit with a bad status or a grant");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.status == ST_OK) || (out_data_o.status == ST_EMPTY)
                     || (out_data_o.status == ST_RANGE)))
    else $error("undefined status code on the result");

endmodule

`default_nettype wire

[hw/rtl/fbfla_link_mem.sv]
`default_nettype none

module fbfla_link_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned DW    = 9
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/fbfla_seq.sv]
`default_nettype none

module fbfla_seq
  import fbfla_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 256,
  parameter int unsigned AW         = 8,
  parameter int unsigned LW         = 9
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             req_valid_i,
  output logic                  req_ready_o,
  input  wire in_item_t         req_i,
  input  wire logic [CNT_W-1:0] count_i,
  output logic                  res_valid_o,
  input  wire logic             res_ready_i,
  output out_item_t             res_o,
  output logic                  mem_we_o,
  output logic [AW-1:0]         mem_waddr_o,
  output logic [LW-1:0]         mem_wdata_o,
  output logic [AW-1:0]         mem_raddr_o,
  input  wire logic [LW-1:0]    mem_rdata_i
);

  localparam int unsigned XW = (LW > IDX_W) ? LW : IDX_W;
  localparam logic [LW-1:0] END_MARK = LW'(MAX_BLOCKS);

  function automatic logic [LW-1:0] clean_link(input logic [LW-1:0] v);
    return (v < END_MARK) ? v : END_MARK;
  endfunction

  seq_state_e state_q, state_d;
  logic [LW-1:0]    head_q, head_d;
  logic [CNT_W-1:0] ctr_q, ctr_d;
  logic [LW-1:0]    cur_q, cur_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  out_item_t        res_q, res_d;

  logic             can_accept;
  logic [LW-1:0]    head_clean;
  logic [CNT_W-1:0] ctr_dec;
  logic [CNT_W-1:0] req_idx_ext;

  assign head_clean  = clean_link(head_q);
  assign ctr_dec     = ctr_q - 1'b1;
  assign req_idx_ext = CNT_W'(req_i.block_index);
  assign can_accept  = (state_q == S_IDLE) || ((state_q == S_DONE) && res_ready_i);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    ctr_d       = ctr_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = head_clean[AW-1:0];
    mem_wdata_o = head_clean;
    mem_raddr_o = head_clean[AW-1:0];
    res_valid_o = 1'b0;
    req_ready_o = can_accept;

    case (state_q)
      S_IDLE: begin
      end
      S_ALLOC_WAIT: begin
        head_d  = clean_link(mem_rdata_i);
        state_d = S_DONE;
      end
      S_RESET_LOOP: begin
        // Links are laid from the top block down, so the head ends at block zero.
        if (ctr_q == '0) begin
          state_d = S_DONE;
        end else begin
          mem_we_o    = 1'b1;
          mem_waddr_o = AW'(ctr_dec);
          mem_wdata_o = head_q;
          head_d      = LW'(ctr_dec);
          ctr_d       = ctr_dec;
        end
      end
      S_QUERY_CHECK: begin
        // The walk is bounded by the count, so a cyclic list still ends.
        if ((cur_q == END_MARK) || (ctr_q >= count_i)) begin
          state_d = S_DONE;
        end else if (XW'(cur_q) == XW'(idx_q)) begin
          res_d.is_free = 1'b1;
          state_d       = S_DONE;
        end else begin
          mem_raddr_o = cur_q[AW-1:0];
          state_d     = S_QUERY_WAIT;
        end
      end
      S_QUERY_WAIT: begin
        cur_d   = clean_link(mem_rdata_i);
        ctr_d   = ctr_q + 1'b1;
        state_d = S_QUERY_CHECK;
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (req_valid_i && can_accept) begin
      res_d = '0;
      case (req_i.op)
        OP_ALLOC: begin
          if (head_clean == END_MARK) begin
            res_d.status = ST_EMPTY;
            state_d      = S_DONE;
          end else begin
            res_d.granted_index = IDX_W'(head_clean);
            mem_raddr_o         = head_clean[AW-1:0];
            state_d             = S_ALLOC_WAIT;
          end
        end
        OP_FREE: begin
          if (req_idx_ext >= count_i) begin
            res_d.status = ST_RANGE;
          end else begin
            mem_we_o    = 1'b1;
            mem_waddr_o = AW'(req_i.block_index);
            mem_wdata_o = head_clean;
            head_d      = LW'(req_i.block_index);
          end
          state_d = S_DONE;
        end
        OP_RESET_ALL: begin
          head_d  = END_MARK;
          ctr_d   = count_i;
          state_d = S_RESET_LOOP;
        end
        OP_QUERY: begin
          idx_d = req_i.block_index;
          if (req_idx_ext >= count_i) begin
            state_d = S_DONE;
          end else begin
            cur_d   = head_clean;
            ctr_d   = '0;
            state_d = S_QUERY_CHECK;
          end
        end
        default: begin
          state_d = S_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= END_MARK;
      ctr_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      ctr_q   <= ctr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    idx_q <= idx_d;
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

`default_nettype wire
